>>> rtl/core/prb_pkg.sv
// Shared types, constants and tables of the perspective range and bearing core.
`default_nettype none
package prb_pkg;

  localparam int COORD_BITS   = 12;
  localparam int CORDIC_ITERS = 18;

  // CORDIC datapath width and angle accumulator width (Q4.30).
  localparam int CW    = 40;
  localparam int ZW    = 34;
  localparam int ANG_W = 18;

  localparam int RANGE_W = 40;
  localparam int MAG_W   = 32;
  localparam int CMAG_W  = 33;
  localparam int NUM_W   = 96;
  localparam int DEN_W   = 64;

  localparam int QDEPTH = 4;
  localparam int ADDR_W = 5;

  localparam logic [31:0] KINV = 32'd2608131496;

  typedef logic signed [COORD_BITS:0] ccoord_t;
  typedef logic [COORD_BITS-1:0] cmag_t;

  typedef struct packed {
    ccoord_t x1;
    ccoord_t y1;
    cmag_t   ax1;
    cmag_t   ay1;
    cmag_t   ax2;
    cmag_t   ay2;
    cmag_t   adx;
    cmag_t   ady;
    logic    same;
  } item_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAME = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_PITCH     = 3'd2,
    REG_FOCAL     = 3'd3,
    REG_LENGTH    = 3'd4
  } reg_e;

  function automatic cmag_t abs_coord(input ccoord_t v);
    ccoord_t n;
    n = -v;
    abs_coord = v[COORD_BITS] ? n[COORD_BITS-1:0] : v[COORD_BITS-1:0];
  endfunction

  // atan(2^-i) in Q2.30.
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    atan_entry = r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/prb_cordic.sv
// Iterative vectoring CORDIC: one micro-rotation per cycle, angle accumulated in z.
`default_nettype none
module prb_cordic (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [prb_pkg::CW-1:0] x0_i,
  input  wire logic signed [prb_pkg::CW-1:0] y0_i,
  output logic                               busy_o,
  output logic signed [prb_pkg::CW-1:0]      x_o,
  output logic signed [prb_pkg::ZW-1:0]      z_o
);

  localparam int IW = $clog2(prb_pkg::CORDIC_ITERS);

  logic signed [prb_pkg::CW-1:0] x_q, y_q, xs, ys;
  logic signed [prb_pkg::ZW-1:0] z_q, ang;
  logic [IW-1:0] cnt_q;
  logic busy_q;

  assign xs  = x_q >>> cnt_q;
  assign ys  = y_q >>> cnt_q;
  assign ang = signed'(prb_pkg::ZW'(prb_pkg::atan_entry(5'(cnt_q))));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == IW'(prb_pkg::CORDIC_ITERS - 1)) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x0_i;
      y_q <= y0_i;
      z_q <= '0;
    end else if (busy_q) begin
      if (!y_q[prb_pkg::CW-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ang;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ang;
      end
    end
  end

  assign busy_o = busy_q;
  assign x_o    = x_q;
  assign z_o    = z_q;

endmodule
`default_nettype wire

>>> rtl/core/prb_front.sv
// Front end: accepts point pairs, centers them and flags coincident points.
`default_nettype none
module prb_front (
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [prb_pkg::COORD_BITS-1:0]    near_x_i,
  input  wire logic [prb_pkg::COORD_BITS-1:0]    near_y_i,
  input  wire logic [prb_pkg::COORD_BITS-1:0]    far_x_i,
  input  wire logic [prb_pkg::COORD_BITS-1:0]    far_y_i,
  input  wire logic [prb_pkg::COORD_BITS-1:0]    center_x_i,
  input  wire logic [prb_pkg::COORD_BITS-1:0]    center_y_i,
  input  wire logic                              q_full_i,
  output logic                                   q_push_o,
  output prb_pkg::item_t                         q_item_o
);

  prb_pkg::ccoord_t x1, y1, x2, y2, dx, dy;

  always_comb begin
    x1 = $signed({1'b0, near_x_i}) - $signed({1'b0, center_x_i});
    y1 = $signed({1'b0, near_y_i}) - $signed({1'b0, center_y_i});
    x2 = $signed({1'b0, far_x_i}) - $signed({1'b0, center_x_i});
    y2 = $signed({1'b0, far_y_i}) - $signed({1'b0, center_y_i});
    dx = $signed({1'b0, far_x_i}) - $signed({1'b0, near_x_i});
    dy = $signed({1'b0, far_y_i}) - $signed({1'b0, near_y_i});
    q_item_o.x1   = x1;
    q_item_o.y1   = y1;
    q_item_o.ax1  = prb_pkg::abs_coord(x1);
    q_item_o.ay1  = prb_pkg::abs_coord(y1);
    q_item_o.ax2  = prb_pkg::abs_coord(x2);
    q_item_o.ay2  = prb_pkg::abs_coord(y2);
    q_item_o.adx  = prb_pkg::abs_coord(dx);
    q_item_o.ady  = prb_pkg::abs_coord(dy);
    q_item_o.same = (near_x_i == far_x_i) && (near_y_i == far_y_i);
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule
`default_nettype wire

>>> rtl/core/prb_queue.sv
// Short FIFO of classified items between the front and back ends.
`default_nettype none
module prb_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire prb_pkg::item_t item_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output prb_pkg::item_t      item_o
);

  localparam int PW = $clog2(prb_pkg::QDEPTH);
  localparam int CNTW = $clog2(prb_pkg::QDEPTH + 1);

  prb_pkg::item_t mem_q [prb_pkg::QDEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CNTW-1:0] cnt_q;

  assign full_o  = (cnt_q == CNTW'(prb_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(prb_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(prb_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/prb_back.sv
// Back end: CORDIC magnitudes and angles, products, range division and result register.
`default_nettype none
module prb_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               q_valid_i,
  input  wire prb_pkg::item_t                     q_item_i,
  output logic                                    q_pop_o,
  input  wire logic [31:0]                        pitch_i,
  input  wire logic [31:0]                        focal_i,
  input  wire logic [31:0]                        length_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [prb_pkg::RANGE_W-1:0]             range_o,
  output logic signed [prb_pkg::ANG_W-1:0]        bearing_h_o,
  output logic signed [prb_pkg::ANG_W-1:0]        bearing_v_o,
  output logic [1:0]                              status_o
);

  localparam int CW = prb_pkg::CW;
  localparam int ZW = prb_pkg::ZW;
  localparam int RW = prb_pkg::RANGE_W;
  localparam int DW = $clog2(prb_pkg::RANGE_W);

  typedef enum logic [2:0] {
    S_IDLE, S_CORD1, S_ISSUE, S_TAKE, S_CORD2, S_CHECK, S_DIV, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_P1, OP_P2, OP_A, OP_PS, OP_C, OP_T, OP_DEN, OP_N0, OP_N1
  } op_e;

  function automatic logic signed [CW-1:0] mag_in(input prb_pkg::cmag_t v);
    mag_in = $signed(CW'({v, 16'h0000}));
  endfunction

  function automatic logic signed [CW-1:0] ang_in(input prb_pkg::ccoord_t v);
    logic signed [CW-1:0] t;
    t = CW'(v);
    ang_in = t <<< 16;
  endfunction

  function automatic logic signed [prb_pkg::ANG_W-1:0] round_ang(
    input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] s;
    s = (z + ZW'(8192)) >>> 14;
    round_ang = s[prb_pkg::ANG_W-1:0];
  endfunction

  state_e state_q;
  op_e    op_q;

  logic [4:0] ustart, ubusy;
  logic signed [CW-1:0] ux0 [5];
  logic signed [CW-1:0] uy0 [5];
  logic signed [CW-1:0] ux  [5];
  logic signed [ZW-1:0] uz  [5];

  logic [31:0] ma, mb;
  logic [7:0]  mh;
  logic [63:0] prod_q;
  logic [39:0] hip_q;
  logic [40:0] mh_res;

  logic [prb_pkg::MAG_W-1:0]  p1_q, p2_q, a_q;
  logic [prb_pkg::CMAG_W-1:0] c_q;
  logic [63:0] t_q;
  logic [prb_pkg::DEN_W-1:0] den_q;
  logic [prb_pkg::NUM_W-1:0] num_q;
  logic [63:0] rem_q;
  logic [RW-1:0] qsh_q;
  logic [DW-1:0] dcnt_q;
  logic [64:0] r2;
  logic ge, ovf;

  logic same_q, hzero_q, vzero_q;
  logic signed [prb_pkg::ANG_W-1:0] bh_q, bv_q;
  logic [RW-1:0] res_range_q;
  prb_pkg::status_e res_status_q;

  logic out_valid_q;
  logic [RW-1:0] range_q;
  logic signed [prb_pkg::ANG_W-1:0] bh_out_q, bv_out_q;
  logic [1:0] status_q;

  logic pop, start_c;

  assign pop     = (state_q == S_IDLE) && q_valid_i;
  assign q_pop_o = pop;
  assign start_c = (state_q == S_TAKE) && (op_q == OP_PS);

  // Unit 0 computes |p1| first and then the hypotenuse c.
  always_comb begin
    ustart    = {pop, pop, pop, pop, pop || start_c};
    ux0[0] = pop ? mag_in(q_item_i.ax1) : $signed(CW'(mh_res[31:0]));
    uy0[0] = pop ? mag_in(q_item_i.ay1) : $signed(CW'(focal_i));
    ux0[1] = mag_in(q_item_i.ax2);
    uy0[1] = mag_in(q_item_i.ay2);
    ux0[2] = mag_in(q_item_i.adx);
    uy0[2] = mag_in(q_item_i.ady);
    ux0[3] = $signed(CW'(focal_i));
    uy0[3] = ang_in(q_item_i.x1);
    ux0[4] = $signed(CW'(focal_i));
    uy0[4] = ang_in(q_item_i.y1);
  end

  for (genvar u = 0; u < 5; u++) begin : g_cordic
    prb_cordic u_cordic (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (ustart[u]),
      .x0_i    (ux0[u]),
      .y0_i    (uy0[u]),
      .busy_o  (ubusy[u]),
      .x_o     (ux[u]),
      .z_o     (uz[u])
    );
  end

  always_comb begin
    ma = '0;
    mb = '0;
    mh = '0;
    unique case (op_q)
      OP_P1:  begin ma = ux[0][31:0]; mh = ux[0][39:32]; mb = prb_pkg::KINV; end
      OP_P2:  begin ma = ux[1][31:0]; mh = ux[1][39:32]; mb = prb_pkg::KINV; end
      OP_A:   begin ma = ux[2][31:0]; mh = ux[2][39:32]; mb = prb_pkg::KINV; end
      OP_PS:  begin ma = p1_q; mb = pitch_i; end
      OP_C:   begin ma = ux[0][31:0]; mh = ux[0][39:32]; mb = prb_pkg::KINV; end
      OP_T:   begin ma = p2_q; mb = length_i; end
      OP_DEN: begin ma = a_q; mb = focal_i; end
      OP_N0:  begin ma = t_q[31:0]; mb = c_q[31:0]; end
      OP_N1:  begin ma = t_q[63:32]; mb = c_q[31:0]; end
      default: begin ma = '0; mb = '0; mh = '0; end
    endcase
  end

  assign mh_res = 41'(prod_q[63:32]) + 41'(hip_q);
  assign r2     = {rem_q, qsh_q[RW-1]};
  assign ge     = (r2 >= {1'b0, den_q});
  assign ovf    = ({8'h00, num_q} >= {den_q, {RW{1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_P1;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop) begin
            state_q <= S_CORD1;
          end
        end
        S_CORD1: begin
          if (ubusy == '0) begin
            if (same_q) begin
              state_q <= S_OUT;
            end else begin
              op_q    <= OP_P1;
              state_q <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          state_q <= S_TAKE;
        end
        S_TAKE: begin
          unique case (op_q)
            OP_P1:  begin op_q <= OP_P2;  state_q <= S_ISSUE; end
            OP_P2:  begin op_q <= OP_A;   state_q <= S_ISSUE; end
            OP_A:   begin op_q <= OP_PS;  state_q <= S_ISSUE; end
            OP_PS:  begin op_q <= OP_C;   state_q <= S_CORD2; end
            OP_C:   begin op_q <= OP_T;   state_q <= S_ISSUE; end
            OP_T:   begin op_q <= OP_DEN; state_q <= S_ISSUE; end
            OP_DEN: begin op_q <= OP_N0;  state_q <= S_ISSUE; end
            OP_N0:  begin op_q <= OP_N1;  state_q <= S_ISSUE; end
            OP_N1:  begin state_q <= S_CHECK; end
            default: state_q <= S_IDLE;
          endcase
        end
        S_CORD2: begin
          if (!ubusy[0]) begin
            state_q <= S_ISSUE;
          end
        end
        S_CHECK: begin
          dcnt_q  <= '0;
          state_q <= ovf ? S_OUT : S_DIV;
        end
        S_DIV: begin
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DW'(RW - 1)) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      same_q  <= q_item_i.same;
      hzero_q <= (q_item_i.x1 == '0) && (focal_i == '0);
      vzero_q <= (q_item_i.y1 == '0) && (focal_i == '0);
    end
    if (state_q == S_CORD1 && ubusy == '0) begin
      bh_q         <= hzero_q ? '0 : round_ang(uz[3]);
      bv_q         <= vzero_q ? '0 : round_ang(uz[4]);
      res_range_q  <= '0;
      res_status_q <= prb_pkg::ST_SAME;
    end
    if (state_q == S_ISSUE) begin
      prod_q <= ma * mb;
      hip_q  <= mh * mb;
    end
    if (state_q == S_TAKE) begin
      unique case (op_q)
        OP_P1:  p1_q  <= mh_res[prb_pkg::MAG_W-1:0];
        OP_P2:  p2_q  <= mh_res[prb_pkg::MAG_W-1:0];
        OP_A:   a_q   <= mh_res[prb_pkg::MAG_W-1:0];
        OP_C:   c_q   <= mh_res[prb_pkg::CMAG_W-1:0];
        OP_T:   t_q   <= prod_q;
        OP_DEN: den_q <= prod_q;
        OP_N0:  num_q <= prb_pkg::NUM_W'(prod_q)
                         + (c_q[prb_pkg::CMAG_W-1] ? {t_q, 32'h0} : '0);
        OP_N1:  num_q <= num_q + {prod_q, 32'h0};
        default: t_q  <= t_q;
      endcase
    end
    if (state_q == S_CHECK) begin
      // A zero denominator also lands here as an overflow.
      if (ovf) begin
        res_range_q  <= '1;
        res_status_q <= prb_pkg::ST_SAT;
      end else begin
        res_status_q <= prb_pkg::ST_OK;
      end
      rem_q <= 64'(num_q[prb_pkg::NUM_W-1:RW]);
      qsh_q <= num_q[RW-1:0];
    end
    if (state_q == S_DIV) begin
      rem_q <= ge ? 64'(r2 - {1'b0, den_q}) : r2[63:0];
      qsh_q <= {qsh_q[RW-2:0], ge};
      if (dcnt_q == DW'(RW - 1)) begin
        res_range_q <= {qsh_q[RW-2:0], ge};
      end
    end
    if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      range_q  <= res_range_q;
      bh_out_q <= bh_q;
      bv_out_q <= bv_q;
      status_q <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign range_o     = range_q;
  assign bearing_h_o = bh_out_q;
  assign bearing_v_o = bv_out_q;
  assign status_o    = status_q;

endmodule
`default_nettype wire

>>> rtl/core/perspective_range_bearing_core.sv
// Top level: configuration registers, front end, item queue and back end.
// Each item takes two CORDIC passes, nine shared 32x32 multiplies and a 40-step restoring
// divider. Coincident points skip the multiplies and the divider after the first pass.
// The back end works on one item at a time; a four-entry queue takes new beats meanwhile.
// Reset restores the default center, pitch, focal length and object length and empties all.
`default_nettype none
module perspective_range_bearing_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [prb_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [prb_pkg::COORD_BITS-1:0]      near_x_i,
  input  wire logic [prb_pkg::COORD_BITS-1:0]      near_y_i,
  input  wire logic [prb_pkg::COORD_BITS-1:0]      far_x_i,
  input  wire logic [prb_pkg::COORD_BITS-1:0]      far_y_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [prb_pkg::RANGE_W-1:0]              range_o,
  output logic signed [prb_pkg::ANG_W-1:0]         bearing_h_o,
  output logic signed [prb_pkg::ANG_W-1:0]         bearing_v_o,
  output logic [1:0]                               status_o
);

  logic [prb_pkg::COORD_BITS-1:0] center_x_q, center_y_q;
  logic [31:0] pitch_q, focal_q, length_q;
  logic wr;
  prb_pkg::reg_e idx;

  logic q_full, q_push, q_valid, q_pop;
  prb_pkg::item_t q_in, q_out;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = prb_pkg::reg_e'(paddr[prb_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= prb_pkg::COORD_BITS'(960);
      center_y_q <= prb_pkg::COORD_BITS'(540);
      pitch_q    <= 32'd4294967;
      focal_q    <= 32'd262144;
      length_q   <= 32'd65536;
    end else if (wr) begin
      unique case (idx)
        prb_pkg::REG_CENTER_X: center_x_q <= pwdata[prb_pkg::COORD_BITS-1:0];
        prb_pkg::REG_CENTER_Y: center_y_q <= pwdata[prb_pkg::COORD_BITS-1:0];
        prb_pkg::REG_PITCH:    pitch_q    <= pwdata;
        prb_pkg::REG_FOCAL:    focal_q    <= pwdata;
        prb_pkg::REG_LENGTH:   length_q   <= pwdata;
        default:               pitch_q    <= pitch_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      prb_pkg::REG_CENTER_X: prdata = 32'(center_x_q);
      prb_pkg::REG_CENTER_Y: prdata = 32'(center_y_q);
      prb_pkg::REG_PITCH:    prdata = pitch_q;
      prb_pkg::REG_FOCAL:    prdata = focal_q;
      prb_pkg::REG_LENGTH:   prdata = length_q;
      default:               prdata = '0;
    endcase
  end

  prb_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .near_x_i   (near_x_i),
    .near_y_i   (near_y_i),
    .far_x_i    (far_x_i),
    .far_y_i    (far_y_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  prb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  prb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .pitch_i     (pitch_q),
    .focal_i     (focal_q),
    .length_i    (length_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .range_o     (range_o),
    .bearing_h_o (bearing_h_o),
    .bearing_v_o (bearing_v_o),
    .status_o    (status_o)
  );

endmodule
`default_nettype wire

>>> sim/perspective_range_bearing_core_test.sv
// Self-checking testbench of the perspective range and bearing core.
`default_nettype none
module perspective_range_bearing_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [prb_pkg::RANGE_W-1:0]      range;
    logic signed [prb_pkg::ANG_W-1:0] bear_h;
    logic signed [prb_pkg::ANG_W-1:0] bear_v;
    prb_pkg::status_e                 status;
  } fix_t;

  localparam logic [63:0] LO32      = 64'hFFFF_FFFF;
  localparam logic [63:0] GAIN_INV  = 64'd2608131496;
  localparam logic [127:0] RANGE_TOP = 128'hFF_FFFF_FFFF;
  localparam longint ATAN_Q30 [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [prb_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [prb_pkg::COORD_BITS-1:0] near_x_i = '0, near_y_i = '0, far_x_i = '0, far_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [prb_pkg::RANGE_W-1:0] range_o;
  logic signed [prb_pkg::ANG_W-1:0] bearing_h_o, bearing_v_o;
  logic [1:0] status_o;

  // Shadow copy of the configuration registers.
  logic [11:0] cfg_cx = 12'd960, cfg_cy = 12'd540;
  logic [31:0] cfg_pitch = 32'd4294967, cfg_focal = 32'd262144, cfg_length = 32'd65536;

  fix_t pending_fixes[$];
  int   mismatches = 0;
  bit   calm = 1'b0;

  perspective_range_bearing_core dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 17);
  endfunction

  function automatic logic [63:0] keep_high32(logic [63:0] a, logic [63:0] k);
    return (a >> 32) * k + (((a & LO32) * k) >> 32);
  endfunction

  // Vectoring CORDIC magnitude with the gain divided out, Q.16.
  function automatic logic [63:0] vector_length(longint x, longint y);
    longint xs, ys;
    for (int i = 0; i < prb_pkg::CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
      end else begin
        x -= ys;
        y += xs;
      end
    end
    return keep_high32(64'(x), GAIN_INV);
  endfunction

  function automatic logic signed [prb_pkg::ANG_W-1:0] view_angle(longint y, longint x);
    longint xs, ys, z;
    z = 0;
    if (x == 0 && y == 0) return '0;
    for (int i = 0; i < prb_pkg::CORDIC_ITERS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += ATAN_Q30[i % 32];
      end else begin
        x -= ys;
        y += xs;
        z -= ATAN_Q30[i % 32];
      end
    end
    z = (z + 8192) >>> 14;
    return z[prb_pkg::ANG_W-1:0];
  endfunction

  function automatic longint mag_of(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic fix_t locate_object(logic [11:0] nx, ny, fx, fy);
    fix_t r;
    longint x1, y1, x2, y2, f;
    logic [63:0] p1, p2, a, ps, c;
    logic [127:0] num, den, q;
    x1 = longint'(nx) - longint'(cfg_cx);
    y1 = longint'(ny) - longint'(cfg_cy);
    x2 = longint'(fx) - longint'(cfg_cx);
    y2 = longint'(fy) - longint'(cfg_cy);
    f = longint'(cfg_focal);
    r.range = '0;
    r.status = prb_pkg::ST_OK;
    if (x1 == x2 && y1 == y2) begin
      r.status = prb_pkg::ST_SAME;
    end else begin
      p1 = vector_length(mag_of(x1) * 65536, mag_of(y1) * 65536);
      p2 = vector_length(mag_of(x2) * 65536, mag_of(y2) * 65536);
      a = vector_length(mag_of(x2 - x1) * 65536, mag_of(y2 - y1) * 65536);
      ps = keep_high32(p1, 64'(cfg_pitch));
      c = vector_length(longint'(ps), f);
      num = 128'(p2) * 128'(cfg_length) * 128'(c);
      den = 128'(a) * 128'(cfg_focal);
      if (den == 0) begin
        r.range = '1;
        r.status = prb_pkg::ST_SAT;
      end else begin
        q = num / den;
        if (q > RANGE_TOP) begin
          r.range = '1;
          r.status = prb_pkg::ST_SAT;
        end else begin
          r.range = q[prb_pkg::RANGE_W-1:0];
        end
      end
    end
    r.bear_h = view_angle(x1 * 65536, f);
    r.bear_v = view_angle(y1 * 65536, f);
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %h expected %h at %t", what, got, want, $realtime);
  endtask

  // Result checker: a beat is taken when valid and ready are seen before the edge.
  initial begin
    fix_t w;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_fixes.size() == 0) begin
          report("unexpected beat", range_o, 0);
        end else begin
          w = pending_fixes.pop_front();
          if (range_o !== w.range) report("range", range_o, w.range);
          if (bearing_h_o !== w.bear_h) report("bearing_h", bearing_h_o, w.bear_h);
          if (bearing_v_o !== w.bear_v) report("bearing_v", bearing_v_o, w.bear_v);
          if (status_o !== w.status) report("status", status_o, w.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !take_break();
  end

  // Called at a rising edge; returns at the edge that accepts the beat.
  task automatic send_points(logic [11:0] nx, ny, fx, fy);
    bit hit;
    if (take_break()) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    near_x_i <= nx;
    near_y_i <= ny;
    far_x_i <= fx;
    far_y_i <= fy;
    do begin
      @(negedge clk_i);
      hit = in_ready_o;
      @(posedge clk_i);
    end while (!hit);
    pending_fixes.push_back(locate_object(nx, ny, fx, fy));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      prb_pkg::REG_CENTER_X: cfg_cx = value[11:0];
      prb_pkg::REG_CENTER_Y: cfg_cy = value[11:0];
      prb_pkg::REG_PITCH:    cfg_pitch = value;
      prb_pkg::REG_FOCAL:    cfg_focal = value;
      prb_pkg::REG_LENGTH:   cfg_length = value;
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] cx, cy, pitch, focal, length);
    write_reg(prb_pkg::REG_CENTER_X, cx);
    write_reg(prb_pkg::REG_CENTER_Y, cy);
    write_reg(prb_pkg::REG_PITCH, pitch);
    write_reg(prb_pkg::REG_FOCAL, focal);
    write_reg(prb_pkg::REG_LENGTH, length);
  endtask

  task automatic random_pair();
    logic [11:0] nx, ny, fx, fy;
    int pick;
    nx = $urandom;
    ny = $urandom;
    fx = $urandom;
    fy = $urandom;
    pick = $urandom_range(99);
    if (pick < 6) begin
      fx = nx;
      fy = ny;
    end else if (pick < 30) begin
      // Close pairs give a tiny baseline and push the range toward saturation.
      fx = nx + 12'($urandom_range(6)) - 12'd3;
      fy = ny + 12'($urandom_range(6)) - 12'd3;
    end else if (pick < 45) begin
      nx = cfg_cx + 12'($urandom_range(40)) - 12'd20;
      ny = cfg_cy + 12'($urandom_range(40)) - 12'd20;
    end
    send_points(nx, ny, fx, fy);
  endtask

  task automatic test_directed();
    send_points(12'd0, 12'd0, 12'd4095, 12'd4095);
    send_points(12'd4095, 12'd4095, 12'd0, 12'd0);
    send_points(12'd960, 12'd540, 12'd1000, 12'd600);
    send_points(12'd100, 12'd200, 12'd100, 12'd200);
    send_points(12'd960, 12'd540, 12'd960, 12'd540);
    send_points(12'd4095, 12'd0, 12'd4094, 12'd0);
    send_points(12'd0, 12'd4095, 12'd0, 12'd4094);
    drain();
    // Long object with adjacent points drives the range into saturation.
    write_reg(prb_pkg::REG_LENGTH, 32'hFFFF_FFFF);
    send_points(12'd4000, 12'd4000, 12'd4001, 12'd4000);
    send_points(12'd0, 12'd0, 12'd0, 12'd1);
    drain();
    // A zero focal length leaves no range denominator.
    write_reg(prb_pkg::REG_FOCAL, 32'd0);
    send_points(12'd960, 12'd540, 12'd10, 12'd20);
    send_points(12'd961, 12'd540, 12'd4095, 12'd4095);
    send_points(12'd10, 12'd10, 12'd10, 12'd10);
    drain();
  endtask

  task automatic test_unmapped_register();
    set_all(32'd960, 32'd540, 32'd4294967, 32'd262144, 32'd65536);
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h0);
    // A wide write to the center X register keeps only the coordinate bits.
    write_reg(prb_pkg::REG_CENTER_X, 32'hFFFF_F123);
    for (int i = 0; i < 6; i++) random_pair();
    drain();
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) random_pair();
    drain();
  endtask

  task automatic test_extreme_configs();
    set_all(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0);
    run_random(90);
    set_all(32'd4095, 32'd4095, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(90);
    set_all(32'd2048, 32'd0, 32'h8000_0000, 32'd65536, 32'hFFFF_FFFF);
    run_random(90);
  endtask

  task automatic test_random_configs();
    set_all(32'd960, 32'd540, 32'd4294967, 32'd262144, 32'd65536);
    calm = 1'b1;
    run_random(150);
    calm = 1'b0;
    for (int k = 0; k < 6; k++) begin
      set_all($urandom, $urandom, $urandom | 32'd1,
              ($urandom_range(1) ? $urandom : 32'($urandom_range(1 << 22, 1))) | 32'd1,
              $urandom);
      run_random(150);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_unmapped_register();
    test_extreme_configs();
    test_random_configs();
    if (mismatches == 0 && pending_fixes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
